// File: rtl/fir_pkg.sv
// fir_pkg: shared types and constants for the fir_filter block
// used by fir_cell, fir_mac and fir_filter; depends on nothing else
package fir_pkg;

  // field widths of the input and result words
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int COEF_IDX_W  = 7;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = 40;
  localparam int FRAC_BITS   = 15;
  localparam int QUOT_W      = ACC_W - FRAC_BITS;
  // wide enough to hold any tap number up to the largest tap count
  localparam int TAP_ID_W    = 9;

  // operation codes carried in the op field
  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_COEF   = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  // control shared by every cell of the ring
  typedef struct packed {
    logic push;    // shift delay line by one, new sample into cell 0
    logic rotate;  // rotate sample and coefficient one cell toward cell 0
  } cell_ctrl_t;

  // control of the multiply-accumulate unit
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // take a product of the head cell this cycle
  } mac_ctrl_t;

endpackage

// File: rtl/fir_cell.sv
// fir_cell: one tap of the ring, holding a delayed sample and its coefficient
// depends on fir_pkg
module fir_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fir_pkg::cell_ctrl_t                 ctrl,
  input  logic                                coef_we,
  input  logic signed [fir_pkg::COEF_W-1:0]   coef_wdata,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] push_sample,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] rot_sample,
  input  logic signed [fir_pkg::COEF_W-1:0]   rot_coef,
  output logic signed [fir_pkg::SAMPLE_W-1:0] sample_o,
  output logic signed [fir_pkg::COEF_W-1:0]   coef_o
);

  logic signed [fir_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;
  logic signed [fir_pkg::COEF_W-1:0]   coef_r, coef_nxt;

  // next contents: push moves samples only, rotate moves both, else coef write
  always_comb begin
    sample_nxt = sample_r;
    coef_nxt   = coef_r;
    if (ctrl.push) begin
      sample_nxt = push_sample;
    end else if (ctrl.rotate) begin
      sample_nxt = rot_sample;
      coef_nxt   = rot_coef;
    end else if (coef_we) begin
      coef_nxt = coef_wdata;
    end
  end

  // cell storage, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      coef_r   <= '0;
    end else begin
      sample_r <= sample_nxt;
      coef_r   <= coef_nxt;
    end
  end

  assign sample_o = sample_r;
  assign coef_o   = coef_r;

endmodule

// File: rtl/fir_mac.sv
// fir_mac: registered multiplier, 40-bit accumulator and output scaling
// depends on fir_pkg
module fir_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fir_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [fir_pkg::COEF_W-1:0]   coef,
  output logic signed [fir_pkg::SAMPLE_W-1:0] result,
  output logic                                sat
);

  localparam logic signed [fir_pkg::QUOT_W-1:0] Q_MAX =
    fir_pkg::QUOT_W'(32767);
  localparam logic signed [fir_pkg::QUOT_W-1:0] Q_MIN =
    -fir_pkg::QUOT_W'(32768);
  localparam logic signed [fir_pkg::ACC_W-1:0] BIAS =
    fir_pkg::ACC_W'((1 << fir_pkg::FRAC_BITS) - 1);

  logic signed [fir_pkg::PROD_W-1:0] prod_r;
  logic                              prod_vld_r;
  logic signed [fir_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [fir_pkg::ACC_W-1:0]  rnd;
  logic signed [fir_pkg::QUOT_W-1:0] quot;

  // product stage
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= sample * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.mul_en;
    end
  end

  // accumulate stage
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (prod_vld_r) begin
      acc_nxt = acc_r + fir_pkg::ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // shift by 15 toward zero: bias negative sums before the arithmetic shift
  always_comb begin
    rnd  = acc_r + (acc_r[fir_pkg::ACC_W-1] ? BIAS : '0);
    quot = fir_pkg::QUOT_W'(rnd >>> fir_pkg::FRAC_BITS);
  end

  // clip to 16 bits
  always_comb begin
    sat    = 1'b0;
    result = fir_pkg::SAMPLE_W'(quot);
    if (quot > Q_MAX) begin
      sat    = 1'b1;
      result = fir_pkg::SAMPLE_W'(Q_MAX);
    end else if (quot < Q_MIN) begin
      sat    = 1'b1;
      result = fir_pkg::SAMPLE_W'(Q_MIN);
    end
  end

endmodule

// File: rtl/fir_filter.sv
// fir_filter: direct-form FIR filter, a ring of tap cells feeding one MAC
// depends on fir_pkg, fir_cell and fir_mac
//
// A filter word (op 0) goes through these steps from acceptance until
// the next word can be taken: the sample is pushed into the delay line,
// every tap of the ring is rotated past the single multiply-accumulate
// unit at cell 0 (one tap per cycle), the product register drains, and
// the result is scaled, clipped and loaded into the result register.
// The ring is back in its home position when the run ends. If the
// previous result has not been taken yet, the last step waits for it.
// A coefficient write (op 1) is taken whenever the block is idle, also
// while a result waits; writes to taps at or beyond TAPS are dropped.
// Reset clears the delay line and all coefficients at once.
module fir_filter #(
  parameter int TAPS = 81
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [fir_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic [fir_pkg::COEF_IDX_W-1:0]      in_coef_index,
  input  logic signed [fir_pkg::COEF_W-1:0]   in_coef_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fir_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                out_saturated
);

  localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;

  fir_pkg::state_t      state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  fir_pkg::cell_ctrl_t  cell_ctrl;
  fir_pkg::mac_ctrl_t   mac_ctrl;
  logic                 in_acc;
  logic                 coef_wr;
  logic                 load_out;
  logic                 cnt_last;

  logic signed [fir_pkg::SAMPLE_W-1:0] cell_sample [TAPS];
  logic signed [fir_pkg::COEF_W-1:0]   cell_coef   [TAPS];
  logic [TAPS-1:0]                     coef_we;

  logic signed [fir_pkg::SAMPLE_W-1:0] mac_result;
  logic                                mac_sat;

  logic signed [fir_pkg::SAMPLE_W-1:0] out_sample_r;
  logic                                out_sat_r;
  logic                                out_valid_r;

  assign in_acc   = in_valid & in_ready;
  assign cnt_last = (cnt_r == CNT_W'(TAPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fir_pkg::ST_IDLE: begin
        if (in_acc && in_op == fir_pkg::OP_FILTER) begin
          state_nxt = fir_pkg::ST_RUN;
        end
      end
      fir_pkg::ST_RUN: begin
        if (cnt_last) begin
          state_nxt = fir_pkg::ST_DRAIN;
        end
      end
      fir_pkg::ST_DRAIN: begin
        state_nxt = fir_pkg::ST_FIN;
      end
      fir_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = fir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fir_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ready         = 1'b0;
    cell_ctrl.push   = 1'b0;
    cell_ctrl.rotate = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    coef_wr          = 1'b0;
    load_out         = 1'b0;
    cnt_nxt          = cnt_r;
    case (state_r)
      fir_pkg::ST_IDLE: begin
        in_ready       = 1'b1;
        cell_ctrl.push = in_valid && in_op == fir_pkg::OP_FILTER;
        mac_ctrl.clear = in_valid && in_op == fir_pkg::OP_FILTER;
        coef_wr        = in_valid && in_op == fir_pkg::OP_COEF;
        cnt_nxt        = '0;
      end
      fir_pkg::ST_RUN: begin
        cell_ctrl.rotate = 1'b1;
        mac_ctrl.mul_en  = 1'b1;
        cnt_nxt          = cnt_r + CNT_W'(1);
      end
      fir_pkg::ST_DRAIN: begin
        cnt_nxt = '0;
      end
      fir_pkg::ST_FIN: begin
        load_out = !out_valid_r || out_ready;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // ring of tap cells; cell 0 holds the newest sample and feeds the mac
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic signed [fir_pkg::SAMPLE_W-1:0] push_sample;

    if (i == 0) begin : g_head
      assign push_sample = in_sample_in;
    end else begin : g_body
      assign push_sample = cell_sample[i-1];
    end

    assign coef_we[i] = coef_wr &&
      ({{(fir_pkg::TAP_ID_W - fir_pkg::COEF_IDX_W){1'b0}}, in_coef_index} ==
       fir_pkg::TAP_ID_W'(i));

    fir_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (cell_ctrl),
      .coef_we     (coef_we[i]),
      .coef_wdata  (in_coef_value),
      .push_sample (push_sample),
      .rot_sample  (cell_sample[(i + 1) % TAPS]),
      .rot_coef    (cell_coef[(i + 1) % TAPS]),
      .sample_o    (cell_sample[i]),
      .coef_o      (cell_coef[i])
    );
  end

  // multiply-accumulate on the head cell
  fir_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .sample (cell_sample[0]),
    .coef   (cell_coef[0]),
    .result (mac_result),
    .sat    (mac_sat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= mac_result;
      out_sat_r    <= mac_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_saturated  = out_sat_r;

  // a run ends only after every tap has passed the mac
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fir_pkg::ST_RUN && state_nxt == fir_pkg::ST_DRAIN) |-> cnt_last)
    else $error("run left before all taps were processed");

  // a pushed sample always starts a run
  a_push_run: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.push |=> state_r == fir_pkg::ST_RUN)
    else $error("sample push did not start a run");

  // no push or coefficient write while the ring is rotating
  a_ring_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cell_ctrl.rotate |-> !cell_ctrl.push && !coef_wr)
    else $error("ring written during rotation");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load_out)
    else $error("result register loaded over a waiting result");

endmodule

// File: verif/tb_fir_filter.sv
// tb_fir_filter: self-checking testbench for the fir_filter block
// depends on fir_pkg and fir_filter; drives filter and coefficient words
// and checks each filtered sample against its tap-line model or a typed value
module tb_fir_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPS     = 81;
  localparam int HOLD_CYC = 700;
  localparam int LIMIT    = 600000;
  localparam int N_DIR    = 23;

  // one filtered sample as seen on the result channel
  typedef struct packed {
    logic [fir_pkg::SAMPLE_W-1:0] y;
    logic                         clip;
  } filt_out_t;

  // one directed word, with a typed-in result where it is obvious
  typedef struct packed {
    logic                           op;
    logic [fir_pkg::SAMPLE_W-1:0]   smp;
    logic [fir_pkg::COEF_IDX_W-1:0] idx;
    logic [fir_pkg::COEF_W-1:0]     cf;
    logic                           known;
    logic [fir_pkg::SAMPLE_W-1:0]   exp_y;
    logic                           exp_clip;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_op;
  logic signed [fir_pkg::SAMPLE_W-1:0] in_sample_in;
  logic [fir_pkg::COEF_IDX_W-1:0] in_coef_index;
  logic signed [fir_pkg::COEF_W-1:0] in_coef_value;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [fir_pkg::SAMPLE_W-1:0] out_sample_out;
  logic out_saturated;

  // tap-line model state
  logic signed [fir_pkg::SAMPLE_W-1:0] taps_line [TAPS];
  logic signed [fir_pkg::COEF_W-1:0]   coef_store [TAPS];
  filt_out_t filtered_q [$];
  filt_out_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int cycles = 0;
  int n_samples = 0;
  int n_writes = 0;
  int n_dropped = 0;
  int n_checked = 0;
  int n_clipped = 0;

  // directed words: reset state, coefficient extremes, dropped taps, clipping
  stim_row_t stim_rows [N_DIR] = '{
    '{fir_pkg::OP_FILTER, 16'h7FFF, 7'd0,   16'h0000, 1'b1, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h8000, 7'd127, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd0,   16'h8000, 1'b0, 16'h0000, 1'b0},
    // most negative squared clips to the top
    '{fir_pkg::OP_FILTER, 16'h8000, 7'd0,   16'h0000, 1'b1, 16'h7FFF, 1'b1},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd0,   16'hFFFF, 1'b0, 16'h0000, 1'b0},
    // a sum of minus one truncates to zero
    '{fir_pkg::OP_FILTER, 16'h0001, 7'd0,   16'h0000, 1'b1, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd0,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h7FFF, 7'd0,   16'h0000, 1'b1, 16'h7FFE, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h8000, 7'd0,   16'h0000, 1'b1, 16'h8001, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd80,  16'h8000, 1'b0, 16'h0000, 1'b0},
    // writes past the last tap are dropped
    '{fir_pkg::OP_COEF,   16'h0000, 7'd81,  16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'hFFFF, 7'd127, 16'h8000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd64,  16'h5555, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd1,   16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h7FFF, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h7FFF, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h8000, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h8000, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h5555, 7'd85,  16'hAAAA, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'hAAAA, 7'd42,  16'h5555, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_FILTER, 16'h0000, 7'd0,   16'h0000, 1'b0, 16'h0000, 1'b0},
    '{fir_pkg::OP_COEF,   16'h0000, 7'd1,   16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  fir_filter #(.TAPS(TAPS)) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_sample_in  (in_sample_in),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_sample_out(out_sample_out),
    .out_saturated (out_saturated)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shift a sample into the tap line and form the clipped dot product
  function automatic filt_out_t filter_predict(
      input logic signed [fir_pkg::SAMPLE_W-1:0] smp);
    logic signed [fir_pkg::ACC_W-1:0] acc;
    logic signed [fir_pkg::ACC_W-1:0] mag;
    logic signed [fir_pkg::ACC_W-1:0] q;
    filt_out_t res;
    for (int i = TAPS - 1; i > 0; i--) taps_line[i] = taps_line[i-1];
    taps_line[0] = smp;
    acc = '0;
    for (int i = 0; i < TAPS; i++) acc = acc + coef_store[i] * taps_line[i];
    // truncate toward zero: scale the magnitude, then restore the sign
    mag = (acc < 0) ? -acc : acc;
    q = mag >>> fir_pkg::FRAC_BITS;
    if (acc < 0) q = -q;
    res.clip = 1'b0;
    if (q > 32767) begin
      q = fir_pkg::ACC_W'(32767);
      res.clip = 1'b1;
    end else if (q < -32768) begin
      q = fir_pkg::ACC_W'(-32768);
      res.clip = 1'b1;
    end
    res.y = q[fir_pkg::SAMPLE_W-1:0];
    return res;
  endfunction

  // offer one word, wait for acceptance, then update the model
  task automatic send_word(input logic op, input logic [fir_pkg::SAMPLE_W-1:0] smp,
                           input logic [fir_pkg::COEF_IDX_W-1:0] idx,
                           input logic [fir_pkg::COEF_W-1:0] cf,
                           input logic known, input filt_out_t typed);
    filt_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_sample_in  <= smp;
    in_coef_index <= idx;
    in_coef_value <= cf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == fir_pkg::OP_FILTER) begin
      pred = filter_predict(smp);
      filtered_q.push_back(known ? typed : pred);
      n_samples++;
    end else if (idx < TAPS) begin
      coef_store[idx] = cf;
      n_writes++;
    end else begin
      n_dropped++;
    end
  endtask

  // stop offering and wait for every pending sample to come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
  endtask

  // blocks of coefficient loads followed by sample bursts with stray writes
  task automatic run_mix(input int n_items, input int idle_pct, input int stall_pct);
    int done_items;
    int cs;
    int ss;
    int nw;
    int ns;
    int k;
    logic first_blk;
    logic [fir_pkg::SAMPLE_W-1:0] r;
    logic [fir_pkg::COEF_IDX_W-1:0] ix;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done_items = 0;
    first_blk = 1'b1;
    while (done_items < n_items) begin
      cs = $urandom_range(14);
      ss = $urandom_range(15);
      // coefficient load, the whole set at the start of a phase
      nw = first_blk ? TAPS : $urandom_range(40, 1);
      for (k = 0; k < nw; k++) begin
        ix = first_blk ? 7'(k) : 7'($urandom_range(TAPS - 1));
        r = 16'($urandom);
        send_word(fir_pkg::OP_COEF, 16'($urandom), ix, 16'($signed(r) >>> cs), 1'b0, '0);
        done_items++;
      end
      first_blk = 1'b0;
      // sample burst
      ns = $urandom_range(40, 8);
      for (k = 0; k < ns; k++) begin
        if ($urandom_range(11) == 0) begin
          // stray write, half of them past the last tap
          ix = $urandom_range(1) ? 7'($urandom_range(127, TAPS)) : 7'($urandom_range(TAPS - 1));
          send_word(fir_pkg::OP_COEF, 16'($urandom), ix, 16'($urandom), 1'b0, '0);
          if (ix < TAPS) done_items++;
        end else begin
          r = 16'($urandom);
          if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
              0: r = 16'h7FFF;
              1: r = 16'h8000;
              2: r = 16'hFFFF;
              default: r = 16'h0000;
            endcase
          end else begin
            r = 16'($signed(r) >>> ss);
          end
          send_word(fir_pkg::OP_FILTER, r, 7'($urandom), 16'($urandom), 1'b0, '0);
          done_items++;
        end
      end
    end
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYC;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word sample_out=%0d saturated=%0b", $time,
                 out_sample_out, out_saturated);
      end else begin
        want = filtered_q.pop_front();
        n_checked++;
        if (out_saturated) n_clipped++;
        if (out_sample_out !== want.y) begin
          err_cnt++;
          $display("%0t: sample_out expected %0d got %0d", $time, $signed(want.y),
                   out_sample_out);
        end
        if (out_saturated !== want.clip) begin
          err_cnt++;
          $display("%0t: saturated expected %0b got %0b", $time, want.clip, out_saturated);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("%0t: timeout with %0d samples pending", $time, filtered_q.size());
      $display("tb_fir_filter: errors");
      $finish;
    end
  end

  // main sequence
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_op         <= fir_pkg::OP_FILTER;
    in_sample_in  <= '0;
    in_coef_index <= '0;
    in_coef_value <= '0;
    for (int i = 0; i < TAPS; i++) begin
      taps_line[i] = '0;
      coef_store[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed words
    for (int i = 0; i < N_DIR; i++) begin
      send_word(stim_rows[i].op, stim_rows[i].smp, stim_rows[i].idx, stim_rows[i].cf,
                stim_rows[i].known, '{stim_rows[i].exp_y, stim_rows[i].exp_clip});
    end
    wait_drained();

    // random phases: free running, idle sender, stalling receiver, both
    run_mix(200, 0, 0);
    wait_drained();
    run_mix(200, 87, 0);
    wait_drained();
    run_mix(200, 0, 87);
    wait_drained();
    run_mix(200, 11, 11);
    wait_drained();

    // long receiver hold-off while samples keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asks++;
    for (int i = 0; i < 12; i++) begin
      send_word(fir_pkg::OP_FILTER, 16'($urandom), '0, '0, 1'b0, '0);
    end
    wait_drained();

    run_mix(240, 11, 11);
    wait_drained();
    repeat (TAPS + 8) @(posedge clk);

    $display("covered %0d samples, %0d coefficient writes, %0d dropped writes",
             n_samples, n_writes, n_dropped);
    $display("checked %0d filtered samples, %0d of them clipped, across idle/stall phases",
             n_checked, n_clipped);
    if (err_cnt == 0 && filtered_q.size() == 0) begin
      $display("tb_fir_filter: clean");
    end else begin
      $display("tb_fir_filter: errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/fir_pkg.sv
rtl/fir_cell.sv
rtl/fir_mac.sv
rtl/fir_filter.sv
verif/tb_fir_filter.sv
